// File: hw/rtl/ccon_pkg.sv
// ccon_pkg: transaction types, action codes and character constants of the
// text console cursor engine. No dependencies; imported by the interfaces, the engine and the testbench.
package ccon_pkg;

    localparam int ACT_W = 4;

    localparam logic [ACT_W-1:0] ACT_PUT       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_LEFT      = 4'd1;
    localparam logic [ACT_W-1:0] ACT_RIGHT     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_BACKSPACE = 4'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 4'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR_PANE = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ENTER_PANE = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SET_COLOR = 4'd7;
    localparam logic [ACT_W-1:0] ACT_READ      = 4'd8;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_BLANK      = 8'h20;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_BAR        = 8'h7C;
    localparam logic [7:0] DEFAULT_COLOR = 8'h0F;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [7:0]       char_code;
        logic [7:0]       color_value;
        logic [10:0]      cell_index;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_line;
        logic [10:0] cursor_offset;
        logic        pane_active;
        logic [7:0]  read_char;
        logic [7:0]  read_color;
        logic        scrolled;
    } t_out_item;

endpackage

// File: hw/rtl/ccon_if.sv
// ccon_in_if, ccon_out_if: valid/ready channels of the console engine.
// Depends on ccon_pkg for the transaction types.
interface ccon_in_if;
    import ccon_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ccon_out_if;
    import ccon_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/text_console_cursor_engine.sv
// text_console_cursor_engine: top level of the text console.
// Depends on ccon_pkg, ccon_if and ccon_ram.
//
// i_in carries one action per transaction (put char, cursor moves, backspace,
// clears, enter pane, set color, read cell); o_out returns one result per
// action with the cursor after the action, the pane flag, read data and a
// scroll flag. Cells (char, color) live in one ram of COLUMNS*ROWS entries.
// Steps: an accepted action passes S_EXEC and then S_OUT, which loads the
// result register; a cell read adds S_READ (one ram read) between the two.
// Scroll, clear and enter-pane actions pass S_PREP, then sweep their region
// one cell a cycle through the ram's write port in S_SCAN before S_OUT.
// The block takes one action at a time; i_in.ready is high while idle, also
// while a finished result still waits in the output register.
// After reset the ram is swept to blanks with color 0x0F, with i_in.ready
// low. When o_out is stalled the result register holds and the next action
// waits in front of its result stage.
module text_console_cursor_engine #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int PANE_LEFT   = 2,
    parameter int PANE_RIGHT  = 77,
    parameter int PANE_TOP    = 3,
    parameter int PANE_BOTTOM = 21
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccon_in_if.sink    i_in,
    ccon_out_if.source o_out
);
    import ccon_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS + 1);

    localparam logic [CW-1:0] C_COLS = CW'(COLUMNS);
    localparam logic [CW-1:0] C_LAST = CW'(COLUMNS - 1);
    localparam logic [CW-1:0] C_PL   = CW'(PANE_LEFT);
    localparam logic [CW-1:0] C_PR   = CW'(PANE_RIGHT);
    localparam logic [RW-1:0] R_ROWS = RW'(ROWS);
    localparam logic [RW-1:0] R_LAST = RW'(ROWS - 1);
    localparam logic [RW-1:0] R_PT   = RW'(PANE_TOP);
    localparam logic [RW-1:0] R_PB   = RW'(PANE_BOTTOM);
    localparam logic [AW-1:0] A_COLS = AW'(COLUMNS);
    localparam logic [AW-1:0] A_PANE = AW'(PANE_TOP * COLUMNS + 1);

    typedef enum logic [2:0] {
        S_SCAN, S_IDLE, S_EXEC, S_PREP, S_READ, S_OUT
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [7:0]       r_color;
    logic             r_pane;
    t_in_item         r_item;
    logic             r_scrolled;
    logic [15:0]      r_rd;
    logic             r_rd_ok;
    logic             r_emit;
    // sweep engine
    logic [CW-1:0]    r_sx;
    logic [RW-1:0]    r_sy;
    logic [AW-1:0]    r_saddr;
    logic [CW-1:0]    r_xlo;
    logic [CW-1:0]    r_xhi;
    logic [RW-1:0]    r_yhi;
    logic             r_copy;
    logic             r_frame;
    logic [7:0]       r_fcolor;
    // write stage, registered after the sweep so copies see the read data
    logic             r_wen;
    logic [AW-1:0]    r_waddr;
    logic [15:0]      r_wfill;
    logic             r_wcopy;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [CW-1:0]    e_col;
    logic [RW-1:0]    e_row;
    logic [CW-1:0]    e_wcol;
    logic [RW-1:0]    e_wrow;
    logic             e_pane;
    logic [7:0]       e_color;
    logic             e_wr;
    logic [7:0]       e_wch;
    logic             e_scr_full;
    logic             e_scr_pane;
    logic             e_clr_full;
    logic             e_clr_pane;
    logic             e_frame;
    logic             e_read;
    logic             do_left;
    logic             do_confine;
    logic             is_bs;

    logic [AW-1:0]    w_addr;
    logic [AW-1:0]    ram_raddr;
    logic [15:0]      ram_rdata;
    logic [15:0]      ram_wdata;
    logic [7:0]       fill_char;
    logic             rule_row;
    logic             edge_col;
    logic             in_range;

    // cursor update and cell write of the action held in r_item
    always_comb begin
        e_col      = r_col;
        e_row      = r_row;
        e_wcol     = r_col;
        e_wrow     = r_row;
        e_pane     = r_pane;
        e_color    = r_color;
        e_wr       = 1'b0;
        e_wch      = CH_BLANK;
        e_scr_full = 1'b0;
        e_scr_pane = 1'b0;
        e_clr_full = 1'b0;
        e_clr_pane = 1'b0;
        e_frame    = 1'b0;
        e_read     = 1'b0;
        do_left    = 1'b0;
        do_confine = 1'b0;
        is_bs      = 1'b0;
        unique case (r_item.action)
            ACT_PUT: begin
                do_confine = 1'b1;
                if (r_item.char_code == CH_NEWLINE) begin
                    e_col = r_pane ? C_PL : '0;
                    e_row = r_row + 1'b1;
                end else begin
                    e_wr  = 1'b1;
                    e_wch = r_item.char_code;
                    e_col = r_col + 1'b1;
                    if (r_pane && e_col > C_PR) begin
                        e_col = C_PL;
                        e_row = r_row + 1'b1;
                    end else if (e_col >= C_COLS) begin
                        e_col = '0;
                        e_row = r_row + 1'b1;
                    end
                end
            end
            ACT_LEFT: do_left = 1'b1;
            ACT_RIGHT: begin
                do_confine = 1'b1;
                e_col = r_col + 1'b1;
                if (!r_pane && e_col >= C_COLS) begin
                    e_col = '0;
                    e_row = r_row + 1'b1;
                end
            end
            ACT_BACKSPACE: begin
                if (!(r_col == '0 && r_row == '0)) begin
                    do_left = 1'b1;
                    is_bs   = 1'b1;
                end
            end
            ACT_CLEAR: begin
                e_pane = 1'b0;
                e_col = '0;
                e_row = '0;
                e_clr_full = 1'b1;
            end
            ACT_CLEAR_PANE: begin
                if (r_pane) begin
                    e_col = C_PL;
                    e_row = R_PT;
                    e_clr_pane = 1'b1;
                end else begin
                    e_col = '0;
                    e_row = '0;
                    e_clr_full = 1'b1;
                end
            end
            ACT_ENTER_PANE: begin
                e_color = DEFAULT_COLOR;
                e_frame = 1'b1;
                e_pane = 1'b1;
                e_col = C_PL;
                e_row = R_PT;
            end
            ACT_SET_COLOR: e_color = r_item.color_value;
            ACT_READ: e_read = 1'b1;
            default: ;
        endcase

        if (do_left) begin
            if (r_pane) begin
                if (e_col > C_PL) begin
                    e_col = e_col - 1'b1;
                end else if (e_row > R_PT) begin
                    e_row = e_row - 1'b1;
                    e_col = C_PR;
                end
            end else begin
                if (e_col > '0) begin
                    e_col = e_col - 1'b1;
                end else if (e_row > '0) begin
                    e_row = e_row - 1'b1;
                    e_col = C_LAST;
                end
            end
        end

        if (do_confine) begin
            if (!r_pane) begin
                if (e_row >= R_ROWS) begin
                    e_row = R_LAST;
                    e_scr_full = 1'b1;
                end
            end else begin
                if (e_col < C_PL) e_col = C_PL;
                if (e_col > C_PR) begin
                    e_col = C_PL;
                    e_row = e_row + 1'b1;
                end
                if (e_row < R_PT) e_row = R_PT;
                if (e_row > R_PB) begin
                    e_row = R_PB;
                    e_col = C_PL;
                    e_scr_pane = 1'b1;
                end
            end
        end

        if (is_bs) begin
            e_wr   = 1'b1;
            e_wch  = CH_BLANK;
            e_wcol = e_col;
            e_wrow = e_row;
        end
    end

    assign w_addr   = AW'(int'(e_wrow) * COLUMNS + int'(e_wcol));
    assign in_range = int'(r_item.cell_index) < CELLS;

    // frame pattern drawn on entering pane mode
    always_comb begin
        rule_row = (r_sy == '0) || (r_sy == RW'(PANE_TOP - 1)) ||
                   (r_sy == RW'(PANE_BOTTOM + 1)) || (r_sy == R_LAST);
        edge_col = (r_sx == '0) || (r_sx == C_LAST);
        if (!r_frame) begin
            fill_char = CH_BLANK;
        end else if (rule_row) begin
            fill_char = edge_col ? CH_PLUS : CH_MINUS;
        end else begin
            fill_char = edge_col ? CH_BAR : CH_BLANK;
        end
    end

    assign ram_raddr = (r_state == S_EXEC) ? AW'(r_item.cell_index) : r_saddr + A_COLS;
    assign ram_wdata = r_wcopy ? ram_rdata : r_wfill;

    ccon_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (r_wen),
        .i_waddr(r_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SCAN;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= DEFAULT_COLOR;
            r_pane      <= 1'b0;
            r_item      <= '0;
            r_emit      <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_saddr     <= '0;
            r_xlo       <= '0;
            r_xhi       <= C_LAST;
            r_yhi       <= R_LAST;
            r_copy      <= 1'b0;
            r_frame     <= 1'b0;
            r_fcolor    <= DEFAULT_COLOR;
            r_wen       <= 1'b0;
            r_wcopy     <= 1'b0;
            r_out_valid <= 1'b0;
            r_scrolled  <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_wen <= 1'b0;
                    if (i_in.valid) begin
                        r_item  <= i_in.data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_col      <= e_col;
                    r_row      <= e_row;
                    r_pane     <= e_pane;
                    r_color    <= e_color;
                    r_scrolled <= e_scr_full | e_scr_pane;
                    r_rd       <= '0;
                    r_rd_ok    <= in_range;
                    r_emit     <= 1'b1;
                    r_wen      <= e_wr;
                    if (e_wr) begin
                        r_waddr <= w_addr;
                        r_wfill <= {e_wch, r_color};
                        r_wcopy <= 1'b0;
                    end
                    r_copy   <= e_scr_full | e_scr_pane;
                    r_frame  <= e_frame;
                    r_fcolor <= e_frame ? DEFAULT_COLOR : r_color;
                    if (e_scr_pane || e_clr_pane) begin
                        r_xlo   <= CW'(1);
                        r_sx    <= CW'(1);
                        r_xhi   <= CW'(COLUMNS - 2);
                        r_sy    <= R_PT;
                        r_yhi   <= R_PB;
                        r_saddr <= A_PANE;
                        r_state <= S_PREP;
                    end else if (e_scr_full || e_clr_full || e_frame) begin
                        r_xlo   <= '0;
                        r_sx    <= '0;
                        r_xhi   <= C_LAST;
                        r_sy    <= '0;
                        r_yhi   <= R_LAST;
                        r_saddr <= '0;
                        r_state <= S_PREP;
                    end else if (e_read) begin
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                // lets the cell write of this action land before the sweep reads
                S_PREP: begin
                    r_wen   <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_wen   <= 1'b1;
                    r_waddr <= r_saddr;
                    r_wcopy <= r_copy && (r_sy != r_yhi);
                    r_wfill <= {fill_char, r_fcolor};
                    if (r_sx == r_xhi) begin
                        r_sx    <= r_xlo;
                        r_sy    <= r_sy + 1'b1;
                        r_saddr <= r_saddr + A_COLS - AW'(r_xhi - r_xlo);
                        if (r_sy == r_yhi) begin
                            r_state <= r_emit ? S_OUT : S_IDLE;
                        end
                    end else begin
                        r_sx    <= r_sx + 1'b1;
                        r_saddr <= r_saddr + 1'b1;
                    end
                end
                S_READ: begin
                    r_wen   <= 1'b0;
                    r_rd    <= r_rd_ok ? ram_rdata : 16'h0000;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_wen <= 1'b0;
                    if (!r_out_valid || o_out.ready) begin
                        r_out.cursor_col    <= 7'(r_col);
                        r_out.cursor_line   <= 5'(r_row);
                        r_out.cursor_offset <= 11'(int'(r_row) * COLUMNS + int'(r_col));
                        r_out.pane_active   <= r_pane;
                        r_out.read_char     <= r_rd[15:8];
                        r_out.read_color    <= r_rd[7:0];
                        r_out.scrolled      <= r_scrolled;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_wen   <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wen |-> int'(r_waddr) < CELLS)
        else $error("cell write outside the store");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_col < C_COLS && r_row < R_ROWS))
        else $error("cursor off screen");

    a_cursor_in_pane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_pane) |->
            (r_col >= C_PL && r_col <= C_PR && r_row >= R_PT && r_row <= R_PB))
        else $error("cursor left the pane");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result loaded outside the result state");
endmodule

// File: hw/rtl/ccon_ram.sv
// ccon_ram: generic simple dual-port ram, one write port and one read port
// with registered read data. No dependencies.
module ccon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: verif/tb.sv
// tb: self-checking testbench of text_console_cursor_engine, predicts every result
// from its own screen model and compares each result transaction field by field.
// Depends on ccon_pkg, ccon_in_if/ccon_out_if and the engine rtl.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccon_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int P_LEFT = 2;
    localparam int P_RIGHT = 77;
    localparam int P_TOP = 3;
    localparam int P_BOTTOM = 21;
    localparam int CELLS = COLS * ROWS;
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 4'd9;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 4'd15;
    localparam int CYCLE_LIMIT = 12000000;

    logic i_clk;
    logic i_rst_n;

    ccon_in_if  in_ch();
    ccon_out_if out_ch();

    text_console_cursor_engine u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // screen model
    logic [7:0] scr_char [CELLS];
    logic [7:0] scr_attr [CELLS];
    int         cur_x;
    int         cur_y;
    logic [7:0] pen;
    bit         pane_on;
    bit         scrolled_now;

    t_out_item  pending_results[$];
    int         send_idle;
    int         recv_idle;
    int         hold_left;
    int         errors;
    int         n_sent;
    int         n_checked;
    int         n_scrolls;
    int         n_reads;
    int         cycles;

    function automatic void poke(int x, int y, logic [7:0] ch);
        if (x < 0 || y < 0 || x >= COLS || y >= ROWS) return;
        scr_char[y*COLS+x] = ch;
        scr_attr[y*COLS+x] = pen;
    endfunction

    function automatic void shift_screen_up();
        for (int y = 1; y < ROWS; y++)
            for (int x = 0; x < COLS; x++) begin
                scr_char[(y-1)*COLS+x] = scr_char[y*COLS+x];
                scr_attr[(y-1)*COLS+x] = scr_attr[y*COLS+x];
            end
        for (int x = 0; x < COLS; x++) poke(x, ROWS-1, CH_BLANK);
        cur_y = ROWS - 1;
        scrolled_now = 1;
    endfunction

    function automatic void scroll_pane_rows();
        for (int y = P_TOP + 1; y <= P_BOTTOM; y++)
            for (int x = 1; x < COLS - 1; x++) begin
                scr_char[(y-1)*COLS+x] = scr_char[y*COLS+x];
                scr_attr[(y-1)*COLS+x] = scr_attr[y*COLS+x];
            end
        for (int x = 1; x < COLS - 1; x++) poke(x, P_BOTTOM, CH_BLANK);
        cur_y = P_BOTTOM;
        cur_x = P_LEFT;
        scrolled_now = 1;
    endfunction

    function automatic void keep_in_bounds();
        if (!pane_on) begin
            if (cur_y >= ROWS) shift_screen_up();
            return;
        end
        if (cur_x < P_LEFT) cur_x = P_LEFT;
        if (cur_x > P_RIGHT) begin
            cur_x = P_LEFT;
            cur_y++;
        end
        if (cur_y < P_TOP) cur_y = P_TOP;
        if (cur_y > P_BOTTOM) scroll_pane_rows();
    endfunction

    function automatic void wipe_all();
        pane_on = 0;
        for (int i = 0; i < CELLS; i++) begin
            scr_char[i] = CH_BLANK;
            scr_attr[i] = pen;
        end
        cur_x = 0;
        cur_y = 0;
    endfunction

    function automatic void step_left();
        if (pane_on) begin
            if (cur_x > P_LEFT) cur_x--;
            else if (cur_y > P_TOP) begin
                cur_y--;
                cur_x = P_RIGHT;
            end
        end else if (cur_x > 0) begin
            cur_x--;
        end else if (cur_y > 0) begin
            cur_y--;
            cur_x = COLS - 1;
        end
    endfunction

    function automatic void rule_row(int y);
        poke(0, y, CH_PLUS);
        for (int x = 1; x < COLS - 1; x++) poke(x, y, CH_MINUS);
        poke(COLS-1, y, CH_PLUS);
    endfunction

    function automatic t_out_item predict(t_in_item it);
        t_out_item r;
        r = '0;
        scrolled_now = 0;
        case (it.action)
            ACT_PUT: begin
                if (it.char_code == CH_NEWLINE) begin
                    cur_x = pane_on ? P_LEFT : 0;
                    cur_y++;
                end else begin
                    keep_in_bounds();
                    poke(cur_x, cur_y, it.char_code);
                    cur_x++;
                    if (pane_on && cur_x > P_RIGHT) begin
                        cur_x = P_LEFT;
                        cur_y++;
                    end else if (cur_x >= COLS) begin
                        cur_x = 0;
                        cur_y++;
                    end
                end
                keep_in_bounds();
            end
            ACT_LEFT: step_left();
            ACT_RIGHT: begin
                cur_x++;
                if (pane_on) keep_in_bounds();
                else begin
                    if (cur_x >= COLS) begin
                        cur_x = 0;
                        cur_y++;
                    end
                    if (cur_y >= ROWS) shift_screen_up();
                end
            end
            ACT_BACKSPACE: begin
                if (!(cur_x == 0 && cur_y == 0)) begin
                    step_left();
                    poke(cur_x, cur_y, CH_BLANK);
                end
            end
            ACT_CLEAR: wipe_all();
            ACT_CLEAR_PANE: begin
                if (!pane_on) wipe_all();
                else begin
                    for (int y = P_TOP; y <= P_BOTTOM; y++)
                        for (int x = 1; x < COLS - 1; x++) poke(x, y, CH_BLANK);
                    cur_x = P_LEFT;
                    cur_y = P_TOP;
                end
            end
            ACT_ENTER_PANE: begin
                pen = DEFAULT_COLOR;
                wipe_all();
                for (int y = 0; y < ROWS; y++) begin
                    poke(0, y, CH_BAR);
                    poke(COLS-1, y, CH_BAR);
                end
                rule_row(0);
                rule_row(P_TOP - 1);
                rule_row(P_BOTTOM + 1);
                rule_row(ROWS - 1);
                cur_x = P_LEFT;
                cur_y = P_TOP;
                pane_on = 1;
            end
            ACT_SET_COLOR: pen = it.color_value;
            ACT_READ: begin
                if (it.cell_index < CELLS) begin
                    r.read_char  = scr_char[it.cell_index];
                    r.read_color = scr_attr[it.cell_index];
                end
            end
            default: ;
        endcase
        r.cursor_col    = cur_x[6:0];
        r.cursor_line   = cur_y[4:0];
        r.cursor_offset = 11'(cur_y * COLS + cur_x);
        r.pane_active   = pane_on;
        r.scrolled      = scrolled_now;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending", cycles,
                         pending_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_out_item got, want;
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                errors++;
                $display("unexpected result transaction at cycle %0d", cycles);
            end else begin
                want = pending_results.pop_front();
                if (got.cursor_col != want.cursor_col)
                    report("cursor_col", got.cursor_col, want.cursor_col);
                if (got.cursor_line != want.cursor_line)
                    report("cursor_line", got.cursor_line, want.cursor_line);
                if (got.cursor_offset != want.cursor_offset)
                    report("cursor_offset", got.cursor_offset, want.cursor_offset);
                if (got.pane_active != want.pane_active)
                    report("pane_active", got.pane_active, want.pane_active);
                if (got.read_char != want.read_char)
                    report("read_char", got.read_char, want.read_char);
                if (got.read_color != want.read_color)
                    report("read_color", got.read_color, want.read_color);
                if (got.scrolled != want.scrolled)
                    report("scrolled", got.scrolled, want.scrolled);
                n_checked++;
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid possibly still high
    task automatic send_action(t_in_item it);
        t_out_item r;
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        r = predict(it);
        if (it.action == ACT_READ) n_reads++;
        if (r.scrolled) n_scrolls++;
        pending_results.push_back(r);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_all_done();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_in_item make_action(logic [ACT_W-1:0] act, logic [7:0] ch,
                                             logic [7:0] col, logic [10:0] idx);
        t_in_item it;
        it.action = act;
        it.char_code = ch;
        it.color_value = col;
        it.cell_index = idx;
        return it;
    endfunction

    function automatic t_in_item random_action();
        t_in_item it;
        int pick;
        it.char_code   = 8'($urandom_range(255));
        it.color_value = 8'($urandom_range(255));
        it.cell_index  = 11'($urandom_range(2047));
        pick = $urandom_range(999);
        if (pick < 470) begin
            it.action = ACT_PUT;
            // newlines often enough to reach the bottom and scroll
            if ($urandom_range(99) < 20) it.char_code = CH_NEWLINE;
        end
        else if (pick < 540) it.action = ACT_LEFT;
        else if (pick < 610) it.action = ACT_RIGHT;
        else if (pick < 680) it.action = ACT_BACKSPACE;
        else if (pick < 688) it.action = ACT_CLEAR;
        else if (pick < 700) it.action = ACT_CLEAR_PANE;
        else if (pick < 715) it.action = ACT_ENTER_PANE;
        else if (pick < 770) it.action = ACT_SET_COLOR;
        else if (pick < 985) begin
            it.action = ACT_READ;
            if ($urandom_range(9) != 0) it.cell_index = 11'($urandom_range(CELLS - 1));
        end
        else it.action = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        return it;
    endfunction

    task automatic test_directed();
        send_action(make_action(ACT_BACKSPACE, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_LEFT, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_SET_COLOR, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_PUT, 8'h00, 8'hFF, 11'h7FF));
        send_action(make_action(ACT_SET_COLOR, 8'hFF, 8'hFF, 11'h7FF));
        send_action(make_action(ACT_PUT, 8'hFF, 8'h00, 11'd0));
        send_action(make_action(ACT_PUT, CH_NEWLINE, 8'h00, 11'd0));
        send_action(make_action(ACT_RIGHT, 8'h41, 8'h00, 11'd0));
        send_action(make_action(ACT_BACKSPACE, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 11'd1));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 11'd1999));
        send_action(make_action(ACT_READ, 8'hFF, 8'hFF, 11'd2000));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 11'h7FF));
        send_action(make_action(ACT_SPARE_LO, 8'h41, 8'h55, 11'd5));
        send_action(make_action(ACT_SPARE_HI, 8'hFF, 8'hFF, 11'h7FF));
        send_action(make_action(ACT_CLEAR_PANE, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_ENTER_PANE, 8'h00, 8'h00, 11'd0));
        // at the first pane cell backspace only blanks that cell
        send_action(make_action(ACT_BACKSPACE, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_PUT, 8'h7E, 8'h00, 11'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 11'(P_TOP*COLS + P_LEFT)));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 11'(P_TOP*COLS)));
        send_action(make_action(ACT_CLEAR_PANE, 8'h00, 8'h00, 11'd0));
        send_action(make_action(ACT_CLEAR, 8'h00, 8'h00, 11'd0));
        wait_all_done();
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (count) send_action(random_action());
        wait_all_done();
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        hold_left = 400;
        // results back up and the sender stalls while the result side holds off
        repeat (16) send_action(make_action(ACT_PUT, 8'($urandom_range(33, 126)), 8'h00, 11'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 11'(cur_y*COLS)));
        wait_all_done();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_left = 0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_scrolls = 0;
        n_reads = 0;
        pen = DEFAULT_COLOR;
        wipe_all();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(460, 25, 77);
        test_backpressure();
        test_random(460, 77, 25);
        test_random(460, 0, 0);
        repeat (50) @(posedge i_clk);
        $display("sent %0d actions, checked %0d results", n_sent, n_checked);
        $display("%0d results scrolled, %0d cell reads, %0d mismatches",
                 n_scrolls, n_reads, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/ccon_pkg.sv
hw/rtl/ccon_if.sv
hw/rtl/ccon_ram.sv
hw/rtl/text_console_cursor_engine.sv
verif/tb.sv
